>>> sv/esc_pkg.sv
// Shared types, constants and tables for the epoch seconds to calendar converter.
// Used by esc_split, esc_cal and epoch_seconds_to_calendar; depends on nothing.
`default_nettype none
package esc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_TZ_OFFSET = 2'd0;
	localparam logic [1:0] REG_HOUR_MODE = 2'd1;

	// Local time window: 2019-01-01 00:00:00 up to 2100-01-01 00:00:00
	localparam logic [33:0] LOCAL_MIN  = 34'd1546300800;
	localparam logic [33:0] LOCAL_SPAN = 34'd2556144000;

	// Day split: rel / 86400 = (rel >> 7) / 675, reciprocal for 25-bit input
	localparam logic [25:0] DAY_RECIP    = 26'd50903317;
	localparam int          DAY_SHIFT    = 35;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	// Four-year groups starting 2017-01-01; 15-bit input
	localparam logic [14:0] DAYS_2017_TO_2019 = 15'd730;
	localparam logic [15:0] QUAD_RECIP        = 16'd45934;
	localparam int          QUAD_SHIFT        = 26;
	localparam logic [10:0] DAYS_PER_QUAD     = 11'd1461;
	localparam logic [11:0] BASE_YEAR         = 12'd2017;

	// Weekday: divide by 7, 15-bit input
	localparam logic [15:0] WEEK_RECIP = 16'd37450;
	localparam int          WEEK_SHIFT = 18;

	// Hour: sod / 3600 = (sod >> 4) / 225, 13-bit input
	localparam logic [13:0] HOUR_RECIP = 14'd9321;
	localparam int          HOUR_SHIFT = 21;

	// Minute count: sod / 60 = (sod >> 2) / 15, 15-bit input
	localparam logic [15:0] MIN_RECIP = 16'd34953;
	localparam int          MIN_SHIFT = 19;

	// Front half to back half of the pipeline
	typedef struct packed {
		logic        vld;
		logic        oor;
		logic        h24_mode;
		logic [16:0] sod;    // second of day
		logic [14:0] dnum;   // days since 2017-01-01
		logic [4:0]  quad;   // four-year group index
		logic [14:0] wdnum;  // days since 2019-01-01 plus one
	} esc_split_t;

	// Finished result
	typedef struct packed {
		logic        vld;
		logic        oor;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  dom;
		logic [8:0]  doy;
		logic [2:0]  wday;
		logic [4:0]  hour;
		logic        is_pm;
		logic [5:0]  minute;
		logic [5:0]  second;
	} esc_result_t;

	// Zero-based day of year at which month m (0..11) starts
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return (m >= 4'd2) ? base + 9'(leap) : base;
	endfunction

endpackage
`default_nettype wire

>>> sv/esc_split.sv
// Front half of the converter: timezone add, range check, day / second-of-day
// split and four-year group index (stages 1 to 3). Depends on esc_pkg.
`default_nettype none
module esc_split (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire logic [31:0]         utc_seconds,
	input  wire logic [16:0]         tz_offset,
	input  wire logic                h24_mode,
	output esc_pkg::esc_split_t      split
);
	import esc_pkg::*;

	logic        vld_s1, vld_s2, vld_s3;
	logic        oor_s1, oor_s2, oor_s3;
	logic        mode_s1, mode_s2, mode_s3;
	logic [31:0] rel_s1;
	logic [16:0] rel_lo_s2;
	logic [14:0] days_s2;
	logic [16:0] sod_s3;
	logic [14:0] dnum_s3;
	logic [4:0]  quad_s3;
	logic [14:0] wdnum_s3;

	logic [33:0] rel;
	logic [50:0] day_prod;
	logic [31:0] day_secs;
	logic [14:0] dnum;
	logic [30:0] quad_prod;

	// Stage 1: local time relative to 2019-01-01, window check
	assign rel = {2'b00, utc_seconds} + {{17{tz_offset[16]}}, tz_offset} - LOCAL_MIN;

	// Stage 2: whole days
	assign day_prod = 51'(rel_s1[31:7]) * 51'(DAY_RECIP);

	// Stage 3: second of day and four-year group
	assign day_secs  = 32'(days_s2) * 32'(SECS_PER_DAY);
	assign dnum      = days_s2 + DAYS_2017_TO_2019;
	assign quad_prod = 31'(dnum) * 31'(QUAD_RECIP);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		oor_s1    <= rel[33] | (rel >= LOCAL_SPAN);
		mode_s1   <= h24_mode;
		rel_s1    <= rel[31:0];

		oor_s2    <= oor_s1;
		mode_s2   <= mode_s1;
		rel_lo_s2 <= rel_s1[16:0];
		days_s2   <= day_prod[DAY_SHIFT+14:DAY_SHIFT];

		oor_s3    <= oor_s2;
		mode_s3   <= mode_s2;
		sod_s3    <= rel_lo_s2 - day_secs[16:0];
		dnum_s3   <= dnum;
		quad_s3   <= quad_prod[QUAD_SHIFT+4:QUAD_SHIFT];
		wdnum_s3  <= days_s2 + 15'd1;
	end

	assign split.vld      = vld_s3;
	assign split.oor      = oor_s3;
	assign split.h24_mode = mode_s3;
	assign split.sod      = sod_s3;
	assign split.dnum     = dnum_s3;
	assign split.quad     = quad_s3;
	assign split.wdnum    = wdnum_s3;

endmodule
`default_nettype wire

>>> sv/esc_cal.sv
// Back half of the converter: year, month, day, weekday and clock fields
// (stages 4 to 6, stage 6 is the output register). Depends on esc_pkg.
`default_nettype none
module esc_cal (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire esc_pkg::esc_split_t split,
	output esc_pkg::esc_result_t     res
);
	import esc_pkg::*;

	logic        vld_s4, vld_s5, vld_s6;
	logic        oor_s4, oor_s5;
	logic        mode_s4;
	logic [10:0] rem_s4;
	logic [4:0]  quad_s4;
	logic [14:0] wdnum_s4;
	logic [12:0] q7_s4;
	logic [16:0] sod_s4;
	logic [4:0]  h24_s4;
	logic [10:0] mtot_s4;

	logic [8:0]  doy0_s5;
	logic        leap_s5;
	logic [11:0] year_s5;
	logic [2:0]  wday_s5;
	logic [4:0]  hour_s5;
	logic        pm_s5;
	logic [5:0]  min_s5;
	logic [5:0]  sec_s5;

	esc_result_t res_s6;

	logic [14:0] quad_days;
	logic [30:0] week_prod;
	logic [26:0] hour_prod;
	logic [30:0] min_prod;

	logic [1:0]  yi;
	logic [10:0] yi_days;
	logic [14:0] wd_mul;
	logic [16:0] min_secs;
	logic [10:0] hour_mins;
	logic [4:0]  hour12;

	logic [3:0]  mon;
	logic [8:0]  mstart;

	// Stage 4: day within group, weekday quotient, hour and minute count
	assign quad_days = 15'(split.quad) * 15'(DAYS_PER_QUAD);
	assign week_prod = 31'(split.wdnum) * 31'(WEEK_RECIP);
	assign hour_prod = 27'(split.sod[16:4]) * 27'(HOUR_RECIP);
	assign min_prod  = 31'(split.sod[16:2]) * 31'(MIN_RECIP);

	// Stage 5: year in group (last year of the group is the leap year)
	always_comb begin
		if (rem_s4 >= 11'd1095) begin
			yi      = 2'd3;
			yi_days = 11'd1095;
		end else if (rem_s4 >= 11'd730) begin
			yi      = 2'd2;
			yi_days = 11'd730;
		end else if (rem_s4 >= 11'd365) begin
			yi      = 2'd1;
			yi_days = 11'd365;
		end else begin
			yi      = 2'd0;
			yi_days = 11'd0;
		end
	end

	assign wd_mul    = 15'(q7_s4) * 15'd7;
	assign min_secs  = 17'(mtot_s4) * 17'd60;
	assign hour_mins = 11'(h24_s4) * 11'd60;

	// 12-hour form: midnight and noon read 12
	always_comb begin
		if (h24_s4 == 5'd0)
			hour12 = 5'd12;
		else if (h24_s4 <= 5'd12)
			hour12 = h24_s4;
		else
			hour12 = h24_s4 - 5'd12;
	end

	// Stage 6: month by compare against each month start
	always_comb begin
		mon = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (doy0_s5 >= month_start(4'(m), leap_s5))
				mon = 4'(m);
		end
	end

	assign mstart = month_start(mon, leap_s5);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= split.vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		oor_s4   <= split.oor;
		mode_s4  <= split.h24_mode;
		rem_s4   <= 11'(split.dnum - quad_days);
		quad_s4  <= split.quad;
		wdnum_s4 <= split.wdnum;
		q7_s4    <= week_prod[WEEK_SHIFT+12:WEEK_SHIFT];
		sod_s4   <= split.sod;
		h24_s4   <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
		mtot_s4  <= min_prod[MIN_SHIFT+10:MIN_SHIFT];

		oor_s5   <= oor_s4;
		doy0_s5  <= 9'(rem_s4 - yi_days);
		leap_s5  <= (yi == 2'd3);
		year_s5  <= BASE_YEAR + {5'd0, quad_s4, 2'b00} + 12'(yi);
		wday_s5  <= 3'(wdnum_s4 - wd_mul);
		hour_s5  <= mode_s4 ? h24_s4 : hour12;
		pm_s5    <= (h24_s4 >= 5'd12);
		min_s5   <= 6'(mtot_s4 - hour_mins);
		sec_s5   <= 6'(sod_s4 - min_secs);

		// valid is carried by vld_s6
		res_s6.vld <= 1'b0;

		// Out of window: every field but the flag reads zero
		res_s6.oor <= oor_s5;
		if (oor_s5) begin
			res_s6.year   <= '0;
			res_s6.month  <= '0;
			res_s6.dom    <= '0;
			res_s6.doy    <= '0;
			res_s6.wday   <= '0;
			res_s6.hour   <= '0;
			res_s6.is_pm  <= 1'b0;
			res_s6.minute <= '0;
			res_s6.second <= '0;
		end else begin
			res_s6.year   <= year_s5;
			res_s6.month  <= mon + 4'd1;
			res_s6.dom    <= 5'(doy0_s5 - mstart + 9'd1);
			res_s6.doy    <= doy0_s5 + 9'd1;
			res_s6.wday   <= wday_s5;
			res_s6.hour   <= hour_s5;
			res_s6.is_pm  <= pm_s5;
			res_s6.minute <= min_s5;
			res_s6.second <= sec_s5;
		end
	end

	always_comb begin
		res     = res_s6;
		res.vld = vld_s6;
	end

endmodule
`default_nettype wire

>>> sv/epoch_seconds_to_calendar.sv
// Top level of the epoch seconds to local calendar converter: configuration
// registers and the six-stage pipeline. Depends on esc_pkg, esc_split, esc_cal.
//
//   channel   handshake              payload
//   request   start / busy           utc_seconds
//   result    done (strobe)          out_of_range, year, month, month_day,
//                                    day_of_year, weekday, hour, is_pm,
//                                    minute, second
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is taken every cycle; its result strobes on done when it leaves
// the six register stages: timezone add, day divide, second-of-day and group
// split, group remainder, year and clock fields, month.
// Reset clears the pipeline valid bits and sets the offset to 0 and 24-hour mode.
// busy stays low and cfg_ready high: there is no backpressure on any side.
`default_nettype none
module epoch_seconds_to_calendar (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output wire logic        busy,
	input  wire logic [31:0] utc_seconds,
	input  wire logic        cfg_valid,
	output wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	output wire logic        done,
	output wire logic        out_of_range,
	output wire logic [11:0] year,
	output wire logic [3:0]  month,
	output wire logic [4:0]  month_day,
	output wire logic [8:0]  day_of_year,
	output wire logic [2:0]  weekday,
	output wire logic [4:0]  hour,
	output wire logic        is_pm,
	output wire logic [5:0]  minute,
	output wire logic [5:0]  second
);
	import esc_pkg::*;

	logic [16:0] tz_offset_q;
	logic        h24_mode_q;

	esc_split_t  split;
	esc_result_t res;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_offset_q <= '0;
			h24_mode_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TZ_OFFSET: tz_offset_q <= cfg_data;
				REG_HOUR_MODE: h24_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	esc_split u_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (start && !busy),
		.utc_seconds (utc_seconds),
		.tz_offset   (tz_offset_q),
		.h24_mode    (h24_mode_q),
		.split       (split)
	);

	esc_cal u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.split  (split),
		.res    (res)
	);

	assign done         = res.vld;
	assign out_of_range = res.oor;
	assign year         = res.year;
	assign month        = res.month;
	assign month_day    = res.dom;
	assign day_of_year  = res.doy;
	assign weekday      = res.wday;
	assign hour         = res.hour;
	assign is_pm        = res.is_pm;
	assign minute       = res.minute;
	assign second       = res.second;

endmodule
`default_nettype wire
